// ===== rtl/lpl_pkg.sv =====
`default_nettype none

package lpl_pkg;

  // register map, word index = paddr / 4
  typedef enum logic [2:0] {
    REG_WINDOW_START = 3'd0,
    REG_WINDOW_END   = 3'd1,
    REG_LEAD_OFFSET  = 3'd2,
    REG_LOOKBACK     = 3'd3,
    REG_NOISE_THR    = 3'd4,
    REG_SAT_THR      = 3'd5
  } reg_idx_t;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  localparam logic [11:0]       RST_WINDOW_START = 12'd7;
  localparam logic [12:0]       RST_WINDOW_END   = 13'd200;
  localparam logic [7:0]        RST_LEAD_OFFSET  = 8'd7;
  localparam logic [7:0]        RST_LOOKBACK     = 8'd50;
  localparam logic signed [7:0] RST_NOISE_THR    = -8'sd110;
  localparam logic signed [7:0] RST_SAT_THR      = 8'sd127;

  // running peak starts here, so nothing at or below it is ever taken
  localparam logic signed [7:0] PEAK_FLOOR = -8'sd125;

  typedef struct packed {
    logic [11:0]       window_start;
    logic [12:0]       window_end;
    logic [7:0]        lead_offset;
    logic [7:0]        lookback;
    logic signed [7:0] noise_threshold;
    logic signed [7:0] saturation_threshold;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/lpl_if.sv =====
`default_nettype none

interface lpl_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] sample;
  logic              last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface lpl_out_if;
  logic        valid;
  logic        ready;
  logic        pulse_found;
  logic [11:0] pulse_bin;
  logic        saturated;

  modport source (output valid, output pulse_found, output pulse_bin, output saturated,
                  input ready);
  modport sink   (input valid, input pulse_found, input pulse_bin, input saturated,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/lpl_cfg_regs.sv =====
`default_nettype none

module lpl_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lpl_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [lpl_pkg::CFG_DW-1:0]  pwdata,
  output logic      [lpl_pkg::CFG_DW-1:0]  prdata,
  output logic                             pready,
  output lpl_pkg::cfg_t                    cfg
);
  import lpl_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_WINDOW_START: cfg_nxt.window_start         = pwdata[11:0];
        REG_WINDOW_END:   cfg_nxt.window_end           = pwdata[12:0];
        REG_LEAD_OFFSET:  cfg_nxt.lead_offset          = pwdata[7:0];
        REG_LOOKBACK:     cfg_nxt.lookback             = pwdata[7:0];
        REG_NOISE_THR:    cfg_nxt.noise_threshold      = pwdata[7:0];
        REG_SAT_THR:      cfg_nxt.saturation_threshold = pwdata[7:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WINDOW_START: prdata = CFG_DW'(cfg_r.window_start);
      REG_WINDOW_END:   prdata = CFG_DW'(cfg_r.window_end);
      REG_LEAD_OFFSET:  prdata = CFG_DW'(cfg_r.lead_offset);
      REG_LOOKBACK:     prdata = CFG_DW'(cfg_r.lookback);
      REG_NOISE_THR:    prdata = CFG_DW'(unsigned'(cfg_r.noise_threshold));
      REG_SAT_THR:      prdata = CFG_DW'(unsigned'(cfg_r.saturation_threshold));
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_start         <= RST_WINDOW_START;
      cfg_r.window_end           <= RST_WINDOW_END;
      cfg_r.lead_offset          <= RST_LEAD_OFFSET;
      cfg_r.lookback             <= RST_LOOKBACK;
      cfg_r.noise_threshold      <= RST_NOISE_THR;
      cfg_r.saturation_threshold <= RST_SAT_THR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lidar_pulse_locator.sv =====
`default_nettype none

// Port       Dir  Handshake     Payload
// in_if      in   valid/ready   sample (s8), last_sample
// out_if     out  valid/ready   pulse_found, pulse_bin (u12), saturated
// psel..     in   APB r/w       window and threshold registers, 4-byte stride
//
// One item per cycle while in_if.ready is high. The waveform state is updated
// at the edge that accepts an item; on the last item the result register loads
// at that same edge, so out_if.valid is high from the next cycle. in_if.ready
// only drops while a result waits and out_if.ready is low.
// Synchronous active-low reset clears the waveform state and out_if.valid and loads the register defaults.
module lidar_pulse_locator #(
  parameter int unsigned MAX_BINS = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  lpl_in_if.sink                           in_if,
  lpl_out_if.source                        out_if,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lpl_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [lpl_pkg::CFG_DW-1:0]  pwdata,
  output logic      [lpl_pkg::CFG_DW-1:0]  prdata,
  output logic                             pready
);
  import lpl_pkg::*;

  localparam int unsigned BW = $clog2(MAX_BINS);
  localparam int unsigned CW = ((BW > 13) ? BW : 13) + 1;
  localparam int unsigned PW = (BW > 12) ? BW : 12;
  localparam logic [BW-1:0] BIN_MAX = BW'(MAX_BINS - 1);

  cfg_t cfg;

  lpl_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [BW-1:0]     bin_r,     bin_nxt;
  logic signed [7:0] peak_val_r, peak_val_nxt;
  logic [BW-1:0]     peak_bin_r, peak_bin_nxt;
  logic              peak_seen_r, peak_seen_nxt;
  logic              stopped_r,  stopped_nxt;
  logic              sat_seen_r, sat_seen_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        found_r;
  logic [11:0] pbin_r;
  logic        sat_r;

  logic              accept;
  logic signed [7:0] s;
  logic [CW-1:0]     i_w, lo_w, hi_w, ws_w, we_w, sum_w;
  logic              in_search, in_sat, take_peak;
  logic [PW-1:0]     pb_ext;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign s           = in_if.sample;

  // window bounds
  always_comb begin
    ws_w  = CW'(cfg.window_start);
    we_w  = CW'(cfg.window_end);
    sum_w = ws_w + CW'(cfg.lead_offset);
    lo_w  = (cfg.window_start > 12'(cfg.lookback))
            ? CW'(cfg.window_start - 12'(cfg.lookback)) : '0;
    hi_w  = (sum_w > we_w) ? we_w : sum_w;
    i_w   = CW'(bin_r);
  end

  always_comb begin
    in_search = !stopped_r && (i_w >= lo_w) && (i_w < hi_w);
    in_sat    = (i_w >= ws_w) && (i_w < we_w) && (s >= cfg.saturation_threshold);
    take_peak = in_search && (s > cfg.noise_threshold) && (s > peak_val_r);

    peak_val_nxt  = take_peak ? s : peak_val_r;
    peak_bin_nxt  = take_peak ? bin_r : peak_bin_r;
    peak_seen_nxt = peak_seen_r || take_peak;
    stopped_nxt   = stopped_r
                    || (in_search && peak_seen_nxt && (s <= cfg.noise_threshold));
    sat_seen_nxt  = sat_seen_r || in_sat;
    bin_nxt       = (bin_r != BIN_MAX) ? bin_r + BW'(1) : bin_r;
    pb_ext        = PW'(peak_bin_nxt);
  end

  always_comb begin
    if (accept && in_if.last_sample) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r       <= '0;
      peak_val_r  <= PEAK_FLOOR;
      peak_bin_r  <= '0;
      peak_seen_r <= 1'b0;
      stopped_r   <= 1'b0;
      sat_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        if (in_if.last_sample) begin
          bin_r       <= '0;
          peak_val_r  <= PEAK_FLOOR;
          peak_bin_r  <= '0;
          peak_seen_r <= 1'b0;
          stopped_r   <= 1'b0;
          sat_seen_r  <= 1'b0;
        end else begin
          bin_r       <= bin_nxt;
          peak_val_r  <= peak_val_nxt;
          peak_bin_r  <= peak_bin_nxt;
          peak_seen_r <= peak_seen_nxt;
          stopped_r   <= stopped_nxt;
          sat_seen_r  <= sat_seen_nxt;
        end
      end
    end
  end

  // result payload, loaded only with the last item of a waveform
  always_ff @(posedge clk) begin
    if (accept && in_if.last_sample) begin
      found_r <= peak_seen_nxt;
      pbin_r  <= peak_seen_nxt ? pb_ext[11:0] : 12'd0;
      sat_r   <= sat_seen_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.pulse_found = found_r;
  assign out_if.pulse_bin   = pbin_r;
  assign out_if.saturated   = sat_r;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lpl_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 500_000;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          ROUND_ITEMS   = 90;
  localparam logic [11:0] LAST_BIN      = 12'd4095;

  // addresses past the register map; writes there must leave everything alone
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum logic [1:0] {ROW_WRITE, ROW_ITEM, ROW_ITEM_CHECKED} row_kind_t;

  typedef struct packed {
    logic        found;
    logic [11:0] bin;
    logic        sat;
  } pulse_report_t;

  typedef struct {
    row_kind_t         kind;
    logic [2:0]        reg_sel;
    logic [31:0]       value;
    logic signed [7:0] smp;
    logic              last;
    pulse_report_t     want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata, prdata;

  lpl_in_if  in_ch();
  lpl_out_if out_ch();

  lidar_pulse_locator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the register file and of the per-waveform tracking state
  cfg_t              cur_cfg;
  logic [11:0]       wf_bin;
  logic signed [7:0] wf_peak;
  logic [11:0]       wf_peak_bin;
  logic              wf_peak_seen, wf_stopped, wf_sat;

  pulse_report_t pulse_reports_due[$];
  stim_row_t     stim_table[$];
  idle_mode_t    idle_mode = IDLE_NONE;

  int unsigned cycle_count = 0;
  int          error_count = 0;
  int          items_accepted = 0;
  int          waveforms_sent = 0;
  int          reports_checked = 0;
  int          writes_done = 0;

  function automatic bit roll(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic int pick(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int stall_pct(input bit sender_side);
    case (idle_mode)
      IDLE_SENDER:   return sender_side ? 71 : 0;
      IDLE_RECEIVER: return sender_side ? 0 : 71;
      IDLE_BOTH:     return 7;
      default:       return 0;
    endcase
  endfunction

  // field value with random junk above its width
  function automatic logic [31:0] with_junk(input int v, input int w);
    return ($urandom << w) | (v & ((1 << w) - 1));
  endfunction

  function automatic void clear_waveform();
    wf_bin       = '0;
    wf_peak      = PEAK_FLOOR;
    wf_peak_bin  = '0;
    wf_peak_seen = 1'b0;
    wf_stopped   = 1'b0;
    wf_sat       = 1'b0;
  endfunction

  function automatic void add_write(input logic [2:0] idx, input int v);
    stim_row_t r;
    r = '{kind: ROW_WRITE, reg_sel: idx, value: v, smp: '0, last: 1'b0, want: '0};
    stim_table.push_back(r);
  endfunction

  function automatic void add_item(input int v, input logic last);
    stim_row_t r;
    r = '{kind: ROW_ITEM, reg_sel: '0, value: '0, smp: 8'(v), last: last, want: '0};
    stim_table.push_back(r);
  endfunction

  function automatic void add_checked(input int v, input logic found, input int bin,
                                      input logic sat);
    stim_row_t r;
    r = '{kind: ROW_ITEM_CHECKED, reg_sel: '0, value: '0, smp: 8'(v), last: 1'b1,
          want: '{found, 12'(bin), sat}};
    stim_table.push_back(r);
  endfunction

  // advance the waveform by one sample; a report comes out on the last one
  task automatic locate_pulse(input logic signed [7:0] s, input logic last,
                              output bit has_report, output pulse_report_t rep);
    int sv, pk, i, lo, hi, ws, we, lb, nt, st;
    sv = s;
    pk = wf_peak;
    i  = wf_bin;
    ws = cur_cfg.window_start;
    we = cur_cfg.window_end;
    lb = cur_cfg.lookback;
    nt = $signed(cur_cfg.noise_threshold);
    st = $signed(cur_cfg.saturation_threshold);
    lo = (ws > lb) ? ws - lb : 0;
    hi = ws + int'(cur_cfg.lead_offset);
    if (hi > we) hi = we;

    if (!wf_stopped && i >= lo && i < hi) begin
      if (sv > nt && sv > pk) begin
        wf_peak      = s;
        wf_peak_bin  = wf_bin;
        wf_peak_seen = 1'b1;
      end
      if (wf_peak_seen && sv <= nt) wf_stopped = 1'b1;
    end
    if (i >= ws && i < we && sv >= st) wf_sat = 1'b1;
    if (wf_bin != LAST_BIN) wf_bin = wf_bin + 12'd1;

    has_report = last;
    rep = '{wf_peak_seen, wf_peak_seen ? wf_peak_bin : 12'd0, wf_sat};
    if (last) clear_waveform();
  endtask

  // called just after a falling edge, returns just after one
  task automatic send_item(input logic signed [7:0] s, input logic last, input bit typed,
                           input pulse_report_t typed_rep);
    bit            got;
    pulse_report_t rep;
    while (roll(stall_pct(1'b1))) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample      <= s;
    in_ch.last_sample <= last;
    do @(posedge clk); while (!in_ch.ready);
    locate_pulse(s, last, got, rep);
    if (got) pulse_reports_due.push_back(typed ? typed_rep : rep);
    items_accepted++;
    if (last) waveforms_sent++;
    @(negedge clk);
  endtask

  // registers only change with the block drained and quiet
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    in_ch.valid <= 1'b0;
    while (pulse_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_WINDOW_START: cur_cfg.window_start         = data[11:0];
      REG_WINDOW_END:   cur_cfg.window_end           = data[12:0];
      REG_LEAD_OFFSET:  cur_cfg.lead_offset          = data[7:0];
      REG_LOOKBACK:     cur_cfg.lookback             = data[7:0];
      REG_NOISE_THR:    cur_cfg.noise_threshold      = data[7:0];
      REG_SAT_THR:      cur_cfg.saturation_threshold = data[7:0];
      default: ;
    endcase
    writes_done++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_waveform(input int len, input bit shaped);
    int k, b, v, ws, nt, st;
    ws = cur_cfg.window_start;
    nt = $signed(cur_cfg.noise_threshold);
    st = $signed(cur_cfg.saturation_threshold);
    for (k = 0; k < len; k++) begin
      b = (k > LAST_BIN) ? LAST_BIN : k;
      if (!shaped)
        v = $urandom_range(255);
      else if (roll(5))
        v = pick(st, 127);
      else if (b + 3 >= ws && b <= ws + 3 && nt < 127)
        // narrow band now and then so that equal peaks turn up
        v = roll(40) ? pick(nt + 1, (nt + 3 > 127) ? 127 : nt + 3) : pick(nt + 1, 127);
      else
        v = pick(-128, nt);
      send_item(8'(v), k == len - 1, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    out_ch.ready <= !roll(stall_pct(1'b0));
  end

  always @(posedge clk) begin
    pulse_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pulse_reports_due.size() == 0) begin
        $display("%0t: unexpected result, expected none actual found=%0d bin=%0d sat=%0d",
                 $time, out_ch.pulse_found, out_ch.pulse_bin, out_ch.saturated);
        error_count++;
      end else begin
        want = pulse_reports_due.pop_front();
        reports_checked++;
        if (out_ch.pulse_found !== want.found) begin
          $display("%0t: pulse_found mismatch, expected %0d actual %0d",
                   $time, want.found, out_ch.pulse_found);
          error_count++;
        end
        if (out_ch.pulse_bin !== want.bin) begin
          $display("%0t: pulse_bin mismatch, expected %0d actual %0d",
                   $time, want.bin, out_ch.pulse_bin);
          error_count++;
        end
        if (out_ch.saturated !== want.sat) begin
          $display("%0t: saturated mismatch, expected %0d actual %0d",
                   $time, want.sat, out_ch.saturated);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pulse_reports_due.size());
      $display("lidar_pulse_locator verification failed");
      $finish;
    end
  end

  initial begin
    int rnd, round_items, ws, we, lead, lb, nt, st;
    in_ch.valid       = 1'b0;
    in_ch.sample      = '0;
    in_ch.last_sample = 1'b0;
    out_ch.ready      = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_n   = 1'b0;
    cur_cfg = '{RST_WINDOW_START, RST_WINDOW_END, RST_LEAD_OFFSET, RST_LOOKBACK,
                RST_NOISE_THR, RST_SAT_THR};
    clear_waveform();

    // reset settings: search bins 0..13, saturation from bin 7
    add_checked(-128, 1'b0, 0, 1'b0);
    // threshold not exceeded, tie keeps bin 1, dip stops search, late spike saturates
    add_item(-110, 1'b0);
    add_item(-100, 1'b0);
    add_item(-100, 1'b0);
    add_item(-110, 1'b0);
    add_item(100, 1'b0);
    add_item(127, 1'b0);
    add_item(-128, 1'b0);
    add_item(127, 1'b1);
    // lowest thresholds: nothing at or below the peak floor can win
    add_write(REG_NOISE_THR, -128);
    add_write(REG_SAT_THR, -128);
    add_item(-125, 1'b0);
    add_item(-126, 1'b0);
    add_checked(-128, 1'b0, 0, 1'b0);
    // both windows empty
    add_write(REG_WINDOW_END, 0);
    add_item(127, 1'b0);
    add_checked(127, 1'b0, 0, 1'b0);
    // windows at the top of the range, never reached by a short waveform
    add_write(REG_WINDOW_START, 4095);
    add_write(REG_WINDOW_END, 4096);
    add_write(REG_LEAD_OFFSET, 255);
    add_write(REG_LOOKBACK, 255);
    add_write(REG_NOISE_THR, 127);
    add_write(REG_SAT_THR, 127);
    add_item(127, 1'b0);
    add_item(127, 1'b0);
    add_checked(127, 1'b0, 0, 1'b0);
    // windows from bin 0
    add_write(REG_WINDOW_START, 0);
    add_write(REG_LOOKBACK, 0);
    add_write(REG_NOISE_THR, 0);
    add_write(REG_SAT_THR, 0);
    add_item(5, 1'b0);
    add_item(9, 1'b0);
    add_item(9, 1'b0);
    add_item(0, 1'b0);
    add_checked(50, 1'b1, 1, 1'b1);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_table[n]) begin
      if (stim_table[n].kind == ROW_WRITE)
        cfg_write(stim_table[n].reg_sel, stim_table[n].value);
      else
        send_item(stim_table[n].smp, stim_table[n].last,
                  stim_table[n].kind == ROW_ITEM_CHECKED, stim_table[n].want);
    end

    for (rnd = 0; rnd <= 7; rnd++) begin
      if (rnd == 0) begin
        ws = 0; we = 4096; lead = 255; lb = 255; nt = -128; st = -128;
      end else begin
        ws   = $urandom_range(40);
        we   = roll(15) ? $urandom_range(ws) : ws + $urandom_range(40);
        lead = roll(10) ? 255 : $urandom_range(30);
        lb   = roll(10) ? 255 : $urandom_range(60);
        nt   = pick(-128, 60);
        st   = roll(10) ? (roll(50) ? 127 : -128) : pick(nt, 127);
      end
      idle_mode = idle_mode_t'(rnd % 4);
      cfg_write(REG_WINDOW_START, with_junk(ws, 12));
      cfg_write(REG_WINDOW_END, with_junk(we, 13));
      cfg_write(REG_LEAD_OFFSET, with_junk(lead, 8));
      cfg_write(REG_LOOKBACK, with_junk(lb, 8));
      cfg_write(REG_NOISE_THR, with_junk(nt, 8));
      cfg_write(REG_SAT_THR, with_junk(st, 8));
      cfg_write(roll(50) ? REG_SPARE_6 : REG_SPARE_7, $urandom);

      round_items = items_accepted;
      while (items_accepted - round_items < ROUND_ITEMS)
        send_waveform($urandom_range(1, 60), roll(80));
    end

    in_ch.valid <= 1'b0;
    while (pulse_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);

    $display("Run: %0d items in %0d waveforms, %0d results checked, %0d register writes",
             items_accepted, waveforms_sent, reports_checked, writes_done);
    $display("Settings covered empty, full-range and out-of-reach windows under all idling modes");
    if (error_count == 0) begin
      $display("lidar_pulse_locator verification clean");
    end else begin
      $display("lidar_pulse_locator verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
